// ===== rtl/skt_pkg.sv =====
// Package for the sorted key table: beat types, command and status codes,
// and default sizing. No dependencies; every other file imports it.
package skt_pkg;

    localparam int KEY_W        = 16;
    localparam int CAPACITY_DEF = 32;

    // Command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_LIST   = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_DELETED   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;
    localparam logic [2:0] ST_ENTRY     = 3'd6;

    typedef struct packed {
        logic [1:0]       command;
        logic [KEY_W-1:0] key;
    } cmd_beat_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [KEY_W-1:0] key_out;
        logic             last;
    } rsp_beat_t;

endpackage

// ===== rtl/skt_mem.sv =====
// Key storage RAM for the sorted key table: one write port, one read port,
// registered read data. Depends on skt_pkg for the key width.
module skt_mem
    import skt_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int AW    = 5
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [KEY_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [KEY_W-1:0] rd_data
);

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data; data holds when not reading
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/skt_ctrl.sv =====
// Command sequencer for the sorted key table: scans, shifts and lists the
// keys held in skt_mem and drives the result register. Depends on skt_pkg.
module skt_ctrl
    import skt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int AW       = 5,
    parameter int CW       = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  cmd_beat_t        cmd,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_beat_t        rsp,
    output logic             wr_en,
    output logic [AW-1:0]    wr_addr,
    output logic [KEY_W-1:0] wr_data,
    output logic             rd_en,
    output logic [AW-1:0]    rd_addr,
    input  logic [KEY_W-1:0] rd_data
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SCAN_RD   = 4'd1;
    localparam logic [3:0] S_SCAN_CMP  = 4'd2;
    localparam logic [3:0] S_INS_CHK   = 4'd3;
    localparam logic [3:0] S_INS_SH_RD = 4'd4;
    localparam logic [3:0] S_INS_SH_WR = 4'd5;
    localparam logic [3:0] S_DEL_SH_RD = 4'd6;
    localparam logic [3:0] S_DEL_SH_WR = 4'd7;
    localparam logic [3:0] S_LIST_RD   = 4'd8;
    localparam logic [3:0] S_LIST_OUT  = 4'd9;
    localparam logic [3:0] S_EMIT      = 4'd10;

    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE     = CW'(1);

    logic [3:0]       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    sh_reg, sh_next;
    logic [1:0]       op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [2:0]       st_reg, st_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_beat_t        rsp_reg, rsp_next;

    logic          out_free;
    logic [CW-1:0] sh_dn, sh_up, idx_up;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign sh_dn     = sh_reg - ONE;
    assign sh_up     = sh_reg + ONE;
    assign idx_up    = idx_reg + ONE;
    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        sh_next        = sh_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        st_next        = st_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg[AW-1:0];
        wr_data        = key_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next  = cmd.command;
                    key_next = cmd.key;
                    idx_next = '0;
                    case (cmd.command)
                        CMD_INSERT:
                        begin
                            state_next = S_SCAN_RD;
                        end
                        CMD_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        CMD_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next    = ST_EMPTY;
                                key_next   = '0;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_LIST_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Scan: read slot idx, or finish when the end is reached
            S_SCAN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    if (op_reg == CMD_INSERT)
                    begin
                        state_next = S_INS_CHK;
                    end
                    else
                    begin
                        st_next    = ST_NOT_FOUND;
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_SCAN_CMP;
                end
            end

            S_SCAN_CMP:
            begin
                if (rd_data == key_reg)
                begin
                    if (op_reg == CMD_INSERT)
                    begin
                        st_next    = ST_DUPLICATE;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        sh_next    = idx_reg;
                        state_next = S_DEL_SH_RD;
                    end
                end
                else if (op_reg == CMD_INSERT && rd_data > key_reg)
                begin
                    state_next = S_INS_CHK;
                end
                else
                begin
                    idx_next   = idx_up;
                    state_next = S_SCAN_RD;
                end
            end

            // Insert position known in idx; reject when full
            S_INS_CHK:
            begin
                if (count_reg == CAP_CNT)
                begin
                    st_next    = ST_FULL;
                    state_next = S_EMIT;
                end
                else
                begin
                    sh_next    = count_reg;
                    state_next = S_INS_SH_RD;
                end
            end

            // Move keys up one slot from the top down to idx
            S_INS_SH_RD:
            begin
                if (sh_reg == idx_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = idx_reg[AW-1:0];
                    wr_data    = key_reg;
                    count_next = count_reg + ONE;
                    st_next    = ST_INSERTED;
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = sh_dn[AW-1:0];
                    state_next = S_INS_SH_WR;
                end
            end

            S_INS_SH_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = sh_reg[AW-1:0];
                wr_data    = rd_data;
                sh_next    = sh_dn;
                state_next = S_INS_SH_RD;
            end

            // Close the gap at the deleted slot, moving keys down
            S_DEL_SH_RD:
            begin
                if (sh_up == count_reg)
                begin
                    count_next = count_reg - ONE;
                    st_next    = ST_DELETED;
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = sh_up[AW-1:0];
                    state_next = S_DEL_SH_WR;
                end
            end

            S_DEL_SH_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = sh_reg[AW-1:0];
                wr_data    = rd_data;
                sh_next    = sh_up;
                state_next = S_DEL_SH_RD;
            end

            // List: one key per read, waits on a full result register
            S_LIST_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_LIST_OUT;
            end

            S_LIST_OUT:
            begin
                if (out_free)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_next.status  = ST_ENTRY;
                    rsp_next.key_out = rd_data;
                    rsp_next.last    = (idx_up == count_reg);
                    idx_next         = idx_up;
                    state_next       = (idx_up == count_reg) ? S_IDLE : S_LIST_RD;
                end
            end

            // Single result beat for insert, delete and empty list
            S_EMIT:
            begin
                if (out_free)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_next.status  = st_reg;
                    rsp_next.key_out = key_reg;
                    rsp_next.last    = 1'b1;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        sh_reg  <= sh_next;
        op_reg  <= op_next;
        key_reg <= key_next;
        st_reg  <= st_next;
        rsp_reg <= rsp_next;
    end

endmodule

// ===== rtl/sorted_key_table.sv =====
// Sorted key table: holds up to CAPACITY distinct 16-bit keys in ascending
// order in a one-port-read, one-port-write RAM. Commands are taken one at a
// time; cmd_stall stays high until the command's last result beat is loaded.
// Every RAM read takes an address step, then a registered data step. Insert
// scans the keys below the new key plus the first larger one, then moves
// each larger stored key up one slot. Delete scans up to the match, then
// moves each key above it down one slot. List reads and emits one key at a
// time. Duplicate, full and not-found results cost the scan alone, and
// not-found scans every stored key; delete or list on an empty table answers
// with no RAM read. A result waiting on rsp_stall holds the sequencer. The
// RAM needs no clearing after reset; only slots below the key count are read.
// Depends on skt_pkg, skt_ctrl and skt_mem.
module sorted_key_table
    import skt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_beat_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_beat_t rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [KEY_W-1:0] wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [KEY_W-1:0] rd_data;

    skt_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    skt_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

`ifndef SYNTHESIS
    // Only list entries may be followed by more beats of the same command
    a_nonlast_is_entry: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |-> rsp.status == ST_ENTRY)
        else $error("non-final result beat that is not a list entry");

    // A real command keeps the table busy in the cycle after its accept
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && cmd.command != CMD_NOP |=> cmd_stall)
        else $error("command accepted without occupying the sequencer");

    // A stalled result beat holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result beat changed");
`endif

endmodule

// ===== tb/skt_table_checker.sv =====
// Checker for the sorted key table: watches both channels, keeps its own copy
// of the stored keys and compares every result beat. Depends on skt_pkg.
module skt_table_checker
    import skt_pkg::*;
#(
    parameter int TABLE_DEPTH = CAPACITY_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  logic      cmd_stall,
    input  cmd_beat_t cmd,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  rsp_beat_t rsp,
    output int        fail_count,
    output int        pending,
    output int        checked_count
);

    timeunit 1ns;
    timeprecision 1ps;

    // Shadow of the table: slots below held_count are sorted ascending
    logic [KEY_W-1:0] held_keys [TABLE_DEPTH];
    int               held_count;
    rsp_beat_t        awaited_rsps [$];
    rsp_beat_t        oldest;
    logic             cmd_predicted;
    int               mismatch_count;
    int               beats_seen;

    function automatic void queue_rsp(logic [2:0] status, logic [KEY_W-1:0] key, logic last);
        rsp_beat_t r;
        r.status  = status;
        r.key_out = key;
        r.last    = last;
        awaited_rsps.push_back(r);
    endfunction

    // Apply one command to the shadow table and queue the beats it yields
    function automatic void apply_command(cmd_beat_t c);
        int pos;
        int i;
        case (c.command)
            CMD_INSERT:
            begin
                pos = 0;
                while (pos < held_count && held_keys[pos] < c.key)
                    pos++;
                if (pos < held_count && held_keys[pos] == c.key)
                    queue_rsp(ST_DUPLICATE, c.key, 1'b1);
                else if (held_count >= TABLE_DEPTH)
                    queue_rsp(ST_FULL, c.key, 1'b1);
                else
                begin
                    for (i = held_count; i > pos; i--)
                        held_keys[i] = held_keys[i-1];
                    held_keys[pos] = c.key;
                    held_count++;
                    queue_rsp(ST_INSERTED, c.key, 1'b1);
                end
            end
            CMD_DELETE:
            begin
                if (held_count == 0)
                    queue_rsp(ST_EMPTY, c.key, 1'b1);
                else
                begin
                    pos = 0;
                    while (pos < held_count && held_keys[pos] != c.key)
                        pos++;
                    if (pos >= held_count)
                        queue_rsp(ST_NOT_FOUND, c.key, 1'b1);
                    else
                    begin
                        for (i = pos; i + 1 < held_count; i++)
                            held_keys[i] = held_keys[i+1];
                        held_count--;
                        queue_rsp(ST_DELETED, c.key, 1'b1);
                    end
                end
            end
            CMD_LIST:
            begin
                if (held_count == 0)
                    queue_rsp(ST_EMPTY, '0, 1'b1);
                else
                    for (i = 0; i < held_count; i++)
                        queue_rsp(ST_ENTRY, held_keys[i], i + 1 == held_count);
            end
            CMD_NOP:
                ;
            default:
                ;
        endcase
    endfunction

    // Predict on the first edge a command is presented (its payload is held
    // until accepted, and result beats may go out before the accept), then
    // compare accepted result beats in order.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count     = 0;
            cmd_predicted  = 1'b0;
            mismatch_count = 0;
            beats_seen     = 0;
            awaited_rsps.delete();
        end
        else
        begin
            if (cmd_valid && !cmd_predicted)
            begin
                apply_command(cmd);
                cmd_predicted = 1'b1;
            end
            if (cmd_valid && !cmd_stall)
                cmd_predicted = 1'b0;

            if (rsp_valid && !rsp_stall)
            begin
                beats_seen++;
                if (awaited_rsps.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] unexpected result beat: status %0d key %h last %b",
                                 $time, rsp.status, rsp.key_out, rsp.last);
                end
                else
                begin
                    oldest = awaited_rsps.pop_front();
                    if (rsp.status !== oldest.status || rsp.key_out !== oldest.key_out ||
                        rsp.last !== oldest.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("[%0t] beat %0d: expected status %0d key %h last %b, got status %0d key %h last %b",
                                     $time, beats_seen, oldest.status, oldest.key_out,
                                     oldest.last, rsp.status, rsp.key_out, rsp.last);
                    end
                end
            end
        end
        fail_count    <= mismatch_count;
        pending       <= awaited_rsps.size();
        checked_count <= beats_seen;
    end

endmodule

// ===== tb/tb_sorted_key_table.sv =====
// Top of the sorted key table testbench: clock, reset, command stimulus and
// the verdict. Depends on skt_pkg, sorted_key_table and skt_table_checker.
module tb_sorted_key_table
    import skt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = CAPACITY_DEF;
    localparam int POOL_SIZE   = TABLE_DEPTH + 4;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_beat_t cmd       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_beat_t rsp;

    int fail_count;
    int pending;
    int checked_count;
    int send_gap_pct = 0;
    int stall_pct    = 0;
    int cmds_sent    = 0;

    sorted_key_table #(.CAPACITY(TABLE_DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    skt_table_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .cmd           (cmd),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Present one command beat, with random idle cycles ahead of it
    task automatic send_beat(input logic [1:0] command, input logic [KEY_W-1:0] key);
        cmd_beat_t b;
        b.command = command;
        b.key     = key;
        while ($urandom_range(99) < send_gap_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= b;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        cmds_sent++;
    endtask

    // Fill to full, mix, then drain, all on a pool of a few more keys than
    // the table can hold so that full and duplicate cases come up.
    task automatic run_phase(input int gap_pct, input int rsp_pct);
        logic [KEY_W-1:0] pool [POOL_SIZE];
        int               start;
        int               r;
        send_gap_pct = gap_pct;
        stall_pct    <= rsp_pct;
        foreach (pool[j])
            pool[j] = KEY_W'($urandom_range(65535));
        pool[0] = '0;
        pool[1] = '1;

        for (int j = 0; j < POOL_SIZE; j++)
            send_beat(CMD_INSERT, pool[j]);
        repeat (2)
            send_beat(CMD_INSERT, pool[$urandom_range(POOL_SIZE-1)]);
        send_beat(CMD_LIST, KEY_W'($urandom));

        repeat (40)
        begin
            r = $urandom_range(99);
            if (r < 45)
                send_beat(CMD_INSERT, pool[$urandom_range(POOL_SIZE-1)]);
            else if (r < 75)
                send_beat(CMD_DELETE, pool[$urandom_range(POOL_SIZE-1)]);
            else if (r < 87)
                send_beat(CMD_LIST, KEY_W'($urandom));
            else if (r < 92)
                send_beat(CMD_NOP, KEY_W'($urandom));
            else
                send_beat(2'($urandom_range(3)), KEY_W'($urandom));
        end

        // 7 is coprime with the pool size, so this visits every pool key
        start = $urandom_range(POOL_SIZE-1);
        for (int j = 0; j < POOL_SIZE; j++)
            send_beat(CMD_DELETE, pool[(start + 7*j) % POOL_SIZE]);
        repeat (2)
            send_beat(CMD_DELETE, pool[$urandom_range(POOL_SIZE-1)]);
        send_beat(CMD_LIST, KEY_W'($urandom));
    endtask

    initial
    begin
        int waited;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        send_gap_pct = 7;
        stall_pct    <= 75;
        @(posedge clk);

        // Directed: empty table, key extremes, duplicate, not found, no-op
        send_beat(CMD_LIST,   16'h0000);
        send_beat(CMD_DELETE, 16'h1234);
        send_beat(CMD_INSERT, 16'h0000);
        send_beat(CMD_INSERT, 16'hFFFF);
        send_beat(CMD_INSERT, 16'h8000);
        send_beat(CMD_INSERT, 16'h8000);
        send_beat(CMD_INSERT, 16'h7FFF);
        send_beat(CMD_LIST,   16'hFFFF);
        send_beat(CMD_DELETE, 16'h1111);
        send_beat(CMD_NOP,    16'hAAAA);
        send_beat(CMD_NOP,    16'h5555);
        send_beat(CMD_DELETE, 16'h0000);
        send_beat(CMD_DELETE, 16'hFFFF);
        send_beat(CMD_DELETE, 16'h8000);
        send_beat(CMD_DELETE, 16'h7FFF);
        send_beat(CMD_LIST,   16'h5A5A);
        send_beat(CMD_DELETE, 16'h0000);

        run_phase(7, 75);
        run_phase(75, 7);
        run_phase(0, 0);
        cmd_valid <= 1'b0;

        // Drain outstanding beats, then allow for a no-result command in flight
        @(posedge clk);
        waited = 0;
        while (pending != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (100)
            @(posedge clk);

        if (pending != 0)
            $display("%0d expected result beats never arrived", pending);
        $display("Ran %0d commands (fill, mix and drain under three stall profiles);",
                 cmds_sent);
        $display("checked %0d result beats, %0d mismatches.", checked_count, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
